// ----- sv/sha_pkg.sv -----
// Package: types, constants and round functions for the SHA-256 stream hasher.
package sha_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       last_byte;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // One queued operation for the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } sha_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_SUM,
    ST_OUT
  } sha_state_t;

  localparam int QueueDepth = 4;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] a);
    big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] e);
    big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] w);
    small_s0 = rotr(w, 7) ^ rotr(w, 18) ^ (w >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] w);
    small_s1 = rotr(w, 17) ^ rotr(w, 19) ^ (w >> 10);
  endfunction

endpackage

// ----- sv/sha_front.sv -----
// Front end: input transfer queue; idle items are dropped here.
module sha_front import sha_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic    clk,
  input  logic    rst,
  input  sha_in_t in_data,
  input  logic    in_valid,
  output logic    in_ready,
  output sha_op_t op,
  output logic    op_valid,
  input  logic    op_ready
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha_op_t        mem [Depth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;
  logic           pop;
  logic           useful;

  assign useful   = in_data.byte_present | in_data.last_byte;
  assign in_ready = (count != (AW + 1)'(Depth));
  assign push     = in_valid & in_ready & useful;
  assign op_valid = (count != '0);
  assign pop      = op_valid & op_ready;
  assign op       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: in_data.message_byte, present: in_data.byte_present,
                       last: in_data.last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end
endmodule

// ----- sv/sha_core.sv -----
// Back end: block buffer, padding sequencer, 64-round compression, digest output.
module sha_core import sha_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  sha_op_t  op,
  input  logic     op_valid,
  output logic     op_ready,
  output sha_out_t out_data,
  output logic     out_valid,
  input  logic     out_ready
);
  sha_state_t  state, state_next;
  logic [31:0] buf_w [16];
  logic [31:0] w [16];
  logic [31:0] chain [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0]  fill;
  logic [63:0] bit_len;
  logic [5:0]  round;
  logic        final_blk;
  logic        need_len;
  logic        pend_last;
  logic [2:0]  out_idx;
  logic        start_comp;
  logic [31:0] w_cur, w_new, t1, t2;
  logic [3:0]  wi;
  logic [1:0]  bi;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [5:0]  wr_addr;

  assign op_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_data  = '{digest_word: chain[out_idx], word_index: out_idx,
                       last_word: (out_idx == 3'd7)};

  assign w_new = small_s1(w[4'(round - 6'd2)]) + w[4'(round - 6'd7)] +
                 small_s0(w[4'(round - 6'd15)]) + w[round[3:0]];
  assign w_cur = (round < 6'd16) ? buf_w[round[3:0]] : w_new;
  assign t1 = h + big_s1(e) + ((e & f) ^ (~e & g)) + RoundK[round] + w_cur;
  assign t2 = big_s0(a) + ((a & b) ^ (a & c) ^ (b & c));

  assign bi = wr_addr[1:0];
  assign wi = wr_addr[5:2];

  always_comb begin
    state_next = state;
    start_comp = 1'b0;
    wr_en      = 1'b0;
    wr_byte    = op.data;
    wr_addr    = fill;
    case (state)
      ST_IDLE: begin
        if (op_valid) begin
          if (op.present) begin
            wr_en = 1'b1;
            if (fill == 6'd63) begin
              state_next = ST_COMP;
              start_comp = 1'b1;
            end else if (op.last) begin
              state_next = ST_PAD;
            end
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        wr_en   = 1'b1;
        wr_byte = PadByte;
        if (fill >= 6'd56) begin
          state_next = ST_COMP;
          start_comp = 1'b1;
        end else begin
          state_next = ST_LEN;
        end
      end
      ST_LEN: begin
        state_next = ST_COMP;
        start_comp = 1'b1;
      end
      ST_COMP: if (round == 6'd63) state_next = ST_SUM;
      ST_SUM: begin
        if (final_blk) state_next = ST_OUT;
        else if (need_len) state_next = ST_LEN;
        else if (pend_last) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_OUT: if (out_ready && out_idx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Buffer holds bytes packed big-endian into words; unwritten tail bytes
  // are zeroed as padding is applied.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_w[wi][8*(3-bi) +: 8] <= wr_byte;
      if (state == ST_PAD) begin
        for (int k = 0; k < 4; k++) if (k > int'(bi)) buf_w[wi][8*(3-k) +: 8] <= 8'h00;
        for (int j = 0; j < 16; j++) if (j > int'(wi)) buf_w[j] <= '0;
      end
    end
    if (state == ST_LEN) begin
      if (need_len) begin
        for (int j = 0; j < 14; j++) buf_w[j] <= '0;
      end
      buf_w[14] <= bit_len[63:32];
      buf_w[15] <= bit_len[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COMP) begin
      w[round[3:0]] <= w_cur;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end else if (start_comp) begin
      a <= chain[0]; b <= chain[1]; c <= chain[2]; d <= chain[3];
      e <= chain[4]; f <= chain[5]; g <= chain[6]; h <= chain[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bit_len   <= '0;
      round     <= '0;
      final_blk <= 1'b0;
      need_len  <= 1'b0;
      pend_last <= 1'b0;
      out_idx   <= '0;
      for (int k = 0; k < 8; k++) chain[k] <= InitChain[k];
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (op_valid) begin
            final_blk <= 1'b0;
            if (op.present) begin
              fill    <= fill + 6'd1;
              bit_len <= bit_len + 64'd8;
              // closing byte fills the block: pad after this compression
              if (op.last && fill == 6'd63) pend_last <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          fill      <= fill + 6'd1;
          // pad in the last eight bytes: length goes in an extra block
          final_blk <= (fill < 6'd56);
          need_len  <= (fill >= 6'd56);
          pend_last <= 1'b0;
        end
        ST_LEN: begin
          final_blk <= 1'b1;
          need_len  <= 1'b0;
        end
        ST_COMP: round <= round + 6'd1;
        ST_SUM: begin
          for (int k = 0; k < 8; k++) chain[k] <= chain[k] + (k == 0 ? a : k == 1 ? b :
            k == 2 ? c : k == 3 ? d : k == 4 ? e : k == 5 ? f : k == 6 ? g : h);
          fill <= '0;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == 3'd7) begin
              fill    <= '0;
              bit_len <= '0;
              for (int k = 0; k < 8; k++) chain[k] <= InitChain[k];
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/sha256_stream_hasher.sv -----
// Top level of the SHA-256 stream hasher.
// Bytes are accepted one per transfer into a short queue and absorbed by
// the back end at one per cycle while it is idle; the cycle that takes every
// 64th byte also loads the round registers, then 64 rounds run one per cycle
// and a sum state adds the result into the chain, and no byte is taken
// until that block is done. A closing transfer adds padding: one
// compression suffices unless the pad byte lands in the last eight bytes
// of a block or the closing byte fills a block, when a second block is
// compressed. The eight digest words then follow, word 0 first, one per
// cycle while the receiver is ready, after which the block is back at its
// initial state.
module sha256_stream_hasher import sha_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic     clk,
  input  logic     rst,
  input  sha_in_t  in_data,
  input  logic     in_valid,
  output logic     in_ready,
  output sha_out_t out_data,
  output logic     out_valid,
  input  logic     out_ready
);
  sha_op_t op;
  logic    op_valid;
  logic    op_ready;

  sha_front #(.Depth(QDepth)) u_front (
    .clk, .rst, .in_data, .in_valid, .in_ready,
    .op, .op_valid, .op_ready
  );

  sha_core u_core (
    .clk, .rst, .op, .op_valid, .op_ready,
    .out_data, .out_valid, .out_ready
  );
endmodule
